### hw/rtl/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg: shared types and constants for the FPU command framer
// Holds the CRC-8 constants, the opcode encoding and the field widths used
// by the framer and its CRC byte step.
// ----------------------------------------------------------------------------
package fcf_pkg;

    // Field widths
    localparam int ACTION_W  = 3;
    localparam int OPERAND_W = 16;
    localparam int BYTE_W    = 8;
    localparam int TAG_W     = 3;

    // Packed request word: action, accumulate, operand_a, operand_b, zero pad
    localparam int IN_TDATA_W = 40;

    // Frame body: header plus up to four operand bytes
    localparam int BODY_W = 5 * BYTE_W;

    // Data byte counts (CRC byte not included)
    localparam logic [2:0] BINARY_BYTES = 3'd5;
    localparam logic [2:0] UNARY_BYTES  = 3'd3;

    // CRC-8 AUTOSAR
    localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h2F;
    localparam logic [BYTE_W-1:0] CRC_INIT   = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_XOROUT = 8'hFF;

    // Opcodes
    typedef enum logic [ACTION_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_ABS = 3'd5,
        OP_SLT = 3'd6,
        OP_NOP = 3'd7
    } opcode_t;

endpackage

### hw/rtl/fpu_command_framer_crc8.sv
// ----------------------------------------------------------------------------
// fpu_command_framer_crc8: FPU command to byte frame with CRC-8 trailer
// Builds header, operand bytes (MSB first) and a CRC-8 AUTOSAR byte for each
// command request and sends them one byte per cycle while m_axis does not stall.
//
//   channel   dir  tdata                                    tlast
//   s_axis    in   action, accumulate, operand_a, operand_b  -
//   m_axis    out  frame_byte                                last_byte
//
// A binary command (add, sub, mul, div) sends six bytes, a unary one four; the next
// request is taken in the cycle its predecessor's CRC byte moves to the output
// register, so frames follow without gaps. The CRC is folded one byte per cycle,
// while m_axis does not stall, as bytes leave the frame register. Reset clears
// the tag to 0 and empties both registers. A stall on m_axis holds the output
// register and the frame register in place.
// ----------------------------------------------------------------------------
module fpu_command_framer_crc8 (
    input  logic                               clk,
    input  logic                               rst_n,
    // request in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [fcf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // action[2:0], accumulate[3],
                                                              // operand_a[19:4],
                                                              // operand_b[35:20], zero[39:36]
    // frame bytes out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fcf_pkg::BYTE_W-1:0]         m_axis_tdata,  // frame_byte[7:0]
    output logic                               m_axis_tlast   // last_byte
);

    // Frame register
    logic                              frame_valid_reg, frame_valid_next;
    logic [2:0]                        left_reg, left_next;
    logic [fcf_pkg::BODY_W-1:0]        body_reg, body_next;
    logic [fcf_pkg::BYTE_W-1:0]        crc_reg, crc_next;
    logic [fcf_pkg::TAG_W-1:0]         tag_reg, tag_next;

    // Output register
    logic                              out_valid_reg, out_valid_next;
    logic [fcf_pkg::BYTE_W-1:0]        out_data_reg, out_data_next;
    logic                              out_last_reg, out_last_next;

    // Request fields
    logic [fcf_pkg::ACTION_W-1:0]      action;
    logic                              accumulate;
    logic [fcf_pkg::OPERAND_W-1:0]     operand_a;
    logic [fcf_pkg::OPERAND_W-1:0]     operand_b;
    logic                              is_binary;
    logic [fcf_pkg::BYTE_W-1:0]        header;

    logic                              out_ready;
    logic                              advance;
    logic                              accept;
    logic [fcf_pkg::BYTE_W-1:0]        cur_byte;
    logic [fcf_pkg::BYTE_W-1:0]        crc_step;

    assign action     = s_axis_tdata[2:0];
    assign accumulate = s_axis_tdata[3];
    assign operand_a  = s_axis_tdata[19:4];
    assign operand_b  = s_axis_tdata[35:20];

    assign is_binary = (action < fcf_pkg::OP_NEG);
    assign header    = {action, accumulate, is_binary, tag_reg};

    // Handshake
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = frame_valid_reg && out_ready;
    assign s_axis_tready = !frame_valid_reg || (out_ready && (left_reg == 3'd0));
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cur_byte = body_reg[fcf_pkg::BODY_W-1 -: fcf_pkg::BYTE_W];

    fcf_crc_step u_crc_step (
        .crc_in  (crc_reg),
        .data_in (cur_byte),
        .crc_out (crc_step)
    );

    // Next-state logic
    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        left_next        = left_reg;
        body_next        = body_reg;
        crc_next         = crc_reg;
        tag_next         = tag_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Send one byte: data bytes first, then the CRC
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (left_reg != 3'd0)
            begin
                out_data_next = cur_byte;
                out_last_next = 1'b0;
                crc_next      = crc_step;
                body_next     = {body_reg[fcf_pkg::BODY_W-fcf_pkg::BYTE_W-1:0],
                                 {fcf_pkg::BYTE_W{1'b0}}};
                left_next     = left_reg - 3'd1;
            end
            else
            begin
                out_data_next    = crc_reg ^ fcf_pkg::CRC_XOROUT;
                out_last_next    = 1'b1;
                frame_valid_next = 1'b0;
            end
        end

        // Load a new request
        if (accept)
        begin
            frame_valid_next = 1'b1;
            body_next        = {header, operand_a, operand_b};
            left_next        = is_binary ? fcf_pkg::BINARY_BYTES : fcf_pkg::UNARY_BYTES;
            crc_next         = fcf_pkg::CRC_INIT;
            tag_next         = tag_reg + fcf_pkg::TAG_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            left_reg        <= 3'd0;
            tag_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            frame_valid_reg <= frame_valid_next;
            left_reg        <= left_next;
            tag_reg         <= tag_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        body_reg     <= body_next;
        crc_reg      <= crc_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### hw/rtl/fcf_crc_step.sv
// ----------------------------------------------------------------------------
// fcf_crc_step: one byte of CRC-8 (poly 0x2F, MSB first)
// Folds one data byte into the running CRC, eight bit steps, no reflection.
// ----------------------------------------------------------------------------
module fcf_crc_step (
    input  logic [fcf_pkg::BYTE_W-1:0] crc_in,
    input  logic [fcf_pkg::BYTE_W-1:0] data_in,
    output logic [fcf_pkg::BYTE_W-1:0] crc_out
);

    // Bitwise shift-and-reduce over the xored byte
    always_comb
    begin
        logic [fcf_pkg::BYTE_W-1:0] c;
        c = crc_in ^ data_in;
        for (int i = 0; i < fcf_pkg::BYTE_W; i++)
        begin
            if (c[fcf_pkg::BYTE_W-1])
            begin
                c = {c[fcf_pkg::BYTE_W-2:0], 1'b0} ^ fcf_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[fcf_pkg::BYTE_W-2:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fpu_command_framer_crc8
// Sends FPU command requests and checks every frame byte against a local
// model of the framer: header layout, operand bytes MSB first, wrapping tag
// and the CRC-8 AUTOSAR trailer. A short table of directed commands comes
// first, then random commands. The sender works in bursts with gaps, and the
// receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DIRECTED_COUNT = 16;
    localparam int RANDOM_COUNT   = 354;
    localparam int HOLD_CYCLES    = 120;

    // One expected byte on the frame output
    typedef struct packed {
        logic [fcf_pkg::BYTE_W-1:0] frame_byte;
        logic                       last_byte;
    } frame_beat_t;

    // One directed command; the header is typed in where it is obvious
    typedef struct packed {
        fcf_pkg::opcode_t                action;
        logic                            accumulate;
        logic [fcf_pkg::OPERAND_W-1:0]   operand_a;
        logic [fcf_pkg::OPERAND_W-1:0]   operand_b;
        logic                            header_typed;
        logic [fcf_pkg::BYTE_W-1:0]      header;
    } command_row_t;

    // Tag starts at 0 after reset and wraps after 7
    localparam command_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        '{fcf_pkg::OP_ADD, 1'b0, 16'h0000, 16'h0000, 1'b1, 8'h08},
        '{fcf_pkg::OP_SUB, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 8'h39},
        '{fcf_pkg::OP_MUL, 1'b0, 16'h8000, 16'h0001, 1'b1, 8'h4A},
        '{fcf_pkg::OP_DIV, 1'b1, 16'h0001, 16'h8000, 1'b1, 8'h7B},
        '{fcf_pkg::OP_NEG, 1'b0, 16'hFFFF, 16'h1234, 1'b1, 8'h84},
        '{fcf_pkg::OP_ABS, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 8'hB5},
        '{fcf_pkg::OP_SLT, 1'b0, 16'h7F80, 16'hFFFF, 1'b1, 8'hC6},
        '{fcf_pkg::OP_NOP, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 8'hF7},
        '{fcf_pkg::OP_ADD, 1'b1, 16'h5555, 16'hAAAA, 1'b1, 8'h18},
        '{fcf_pkg::OP_NOP, 1'b0, 16'h0000, 16'h0000, 1'b1, 8'hE1},
        '{fcf_pkg::OP_ADD, 1'b0, 16'h3F80, 16'h4000, 1'b0, 8'h00},
        '{fcf_pkg::OP_NEG, 1'b1, 16'hAAAA, 16'h5555, 1'b0, 8'h00},
        '{fcf_pkg::OP_MUL, 1'b1, 16'hFF7F, 16'h0080, 1'b0, 8'h00},
        '{fcf_pkg::OP_DIV, 1'b0, 16'h7FC0, 16'hFF80, 1'b0, 8'h00},
        '{fcf_pkg::OP_NOP, 1'b0, 16'h1234, 16'hFFFF, 1'b0, 8'h00},
        '{fcf_pkg::OP_SLT, 1'b1, 16'h0000, 16'h0000, 1'b0, 8'h00}
    };

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [fcf_pkg::IN_TDATA_W-1:0]   s_axis_tdata;   // action[2:0], accumulate[3],
                                                      // operand_a[19:4],
                                                      // operand_b[35:20], zero[39:36]
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [fcf_pkg::BYTE_W-1:0]       m_axis_tdata;   // frame_byte[7:0]
    logic                             m_axis_tlast;   // last_byte

    // Model state and bookkeeping
    frame_beat_t                      frame_bytes_due[$];
    logic [fcf_pkg::TAG_W-1:0]        frame_tag;
    int                               error_count;
    int                               bytes_checked;
    int                               frames_binary;
    int                               frames_unary;
    int                               opcode_seen [8];
    bit                               hold_done;

    fpu_command_framer_crc8 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d frame bytes still due", frame_bytes_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // CRC-8 AUTOSAR, one byte folded in, MSB first
    function automatic logic [fcf_pkg::BYTE_W-1:0] crc8_fold(
        input logic [fcf_pkg::BYTE_W-1:0] crc,
        input logic [fcf_pkg::BYTE_W-1:0] data);
        logic [fcf_pkg::BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = (c << 1) ^ fcf_pkg::CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

    // Work out the bytes of one frame and queue them
    task automatic build_command_frame(input fcf_pkg::opcode_t              action,
                                       input logic                          accumulate,
                                       input logic [fcf_pkg::OPERAND_W-1:0] operand_a,
                                       input logic [fcf_pkg::OPERAND_W-1:0] operand_b,
                                       input logic                          header_typed,
                                       input logic [fcf_pkg::BYTE_W-1:0]    header);
        logic [fcf_pkg::BYTE_W-1:0] body [5];
        logic [fcf_pkg::BYTE_W-1:0] crc;
        logic                       is_binary;
        int                         nbytes;
        is_binary = (action <= fcf_pkg::OP_DIV);
        body[0] = header_typed ? header : {action, accumulate, is_binary, frame_tag};
        body[1] = operand_a[15:8];
        body[2] = operand_a[7:0];
        body[3] = operand_b[15:8];
        body[4] = operand_b[7:0];
        nbytes = is_binary ? 5 : 3;
        frame_tag = frame_tag + 1'b1;
        crc = fcf_pkg::CRC_INIT;
        for (int k = 0; k < nbytes; k++)
        begin
            crc = crc8_fold(crc, body[k]);
            frame_bytes_due.push_back('{frame_byte: body[k], last_byte: 1'b0});
        end
        frame_bytes_due.push_back('{frame_byte: crc ^ fcf_pkg::CRC_XOROUT,
                                    last_byte: 1'b1});
        if (is_binary)
            frames_binary++;
        else
            frames_unary++;
        opcode_seen[action]++;
    endtask

    // Offer one request and wait until it is taken
    task automatic offer_command(input command_row_t row);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, row.operand_b, row.operand_a, row.accumulate, row.action};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        build_command_frame(row.action, row.accumulate, row.operand_a, row.operand_b,
                            row.header_typed, row.header);
    endtask

    // Operands lean on the bfloat16 corner patterns now and then
    function automatic logic [fcf_pkg::OPERAND_W-1:0] pick_operand();
        logic [fcf_pkg::OPERAND_W-1:0] corners [6];
        corners = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h7F80, 16'hFF80};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 5)];
        return fcf_pkg::OPERAND_W'($urandom);
    endfunction

    // Request side: directed table, then random commands in bursts
    initial
    begin
        command_row_t row;
        int           burst_left;
        int           gap;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        frame_tag     = '0;
        error_count   = 0;
        bytes_checked = 0;
        frames_binary = 0;
        frames_unary  = 0;
        foreach (opcode_seen[i])
            opcode_seen[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < DIRECTED_COUNT + RANDOM_COUNT; n++)
        begin
            if (n < DIRECTED_COUNT)
                row = DIRECTED_ROWS[n];
            else
            begin
                row.action       = fcf_pkg::opcode_t'($urandom_range(0, 7));
                row.accumulate   = 1'($urandom);
                row.operand_a    = pick_operand();
                row.operand_b    = pick_operand();
                row.header_typed = 1'b0;
                row.header       = '0;
            end
            offer_command(row);
            burst_left--;
            if (n == DIRECTED_COUNT + RANDOM_COUNT - 1)
                s_axis_tvalid <= 1'b0;
            else if (burst_left == 0)
            begin
                gap = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 12);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        // Drain, then watch a little longer for stray bytes
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Run: %0d commands framed (%0d binary, %0d unary), %0d frame bytes checked",
                 frames_binary + frames_unary, frames_binary, frames_unary, bytes_checked);
        $display("Opcodes add..nop: %0d %0d %0d %0d %0d %0d %0d %0d, mismatches: %0d",
                 opcode_seen[0], opcode_seen[1], opcode_seen[2], opcode_seen[3],
                 opcode_seen[4], opcode_seen[5], opcode_seen[6], opcode_seen[7],
                 error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Byte side: randomly chosen stall modes that change over the run, plus one
    // long hold-off so the framer backs up into its request input
    initial
    begin
        int mode;
        int mode_left;
        int period;
        int phase;
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        mode          = 0;
        mode_left     = 0;
        period        = 2;
        phase         = 0;
        forever
        begin
            if (!hold_done && bytes_checked >= 400)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 60);
                    period    = $urandom_range(2, 5);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 99) >= 35);
                    default: m_axis_tready <= (phase % period == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Compare every accepted frame byte with the oldest expected one
    always @(posedge clk)
    begin
        frame_beat_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                error_count++;
                $error("unexpected frame byte %02h last %0b", m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                due = frame_bytes_due.pop_front();
                bytes_checked++;
                if (m_axis_tdata !== due.frame_byte)
                begin
                    error_count++;
                    $error("frame_byte: expected %02h, got %02h", due.frame_byte, m_axis_tdata);
                end
                if (m_axis_tlast !== due.last_byte)
                begin
                    error_count++;
                    $error("last_byte: expected %0b, got %0b", due.last_byte, m_axis_tlast);
                end
            end
        end
    end

endmodule

### filelist.f
hw/rtl/fcf_pkg.sv
hw/rtl/fcf_crc_step.sv
hw/rtl/fpu_command_framer_crc8.sv
dv/testbench.sv
